/* src/rfa_pkg.sv */
// Shared constants for the rational fraction ALU.
package rfa_pkg;
    localparam int NUM_BITS = 35;
    localparam int DEN_BITS = 32;
    localparam int IN_FIELD_BITS = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef logic [NUM_BITS-1:0] t_res_num;
    typedef logic [DEN_BITS-1:0] t_res_den;
endpackage

/* src/rational_fraction_alu_unit.sv */
// Top level: sequencer, multiplier and output register around the serial divider.
// Usage: one item per slave-side transfer carries two fractions and an
// operation code in tuser (0 add, 1 subtract, 2 multiply, 3 divide).
// The result goes out as one master-side transfer: reduced numerator with
// sign and positive denominator in tdata, error status in tuser.
// A zero denominator or a divide by zero gives status 1 with 0/0.
// o_s_tready is high only while the sequencer is idle; one item at a time.
// Flow: every divide runs on the shared serial divider of width
// W = 2*OPERAND_BITS+1. Add/subtract run a gcd of the denominators, two
// divides, three multiplies, then a gcd of the result and two divides;
// multiply/divide skip the first gcd, its two divides and one multiply.
// Each gcd costs one divide per Euclid step; a zero sum skips the last gcd
// and its two divides.
// An input error goes from the check step straight to the output step.
// A finished result waits in the output register while the next item
// is already taken in; if the receiver stalls, the sequencer holds at its
// last step until the register frees. Reset empties the output register
// and returns the sequencer to idle.
module rational_fraction_alu_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // num_a, den_a, num_b, den_b
    input  logic [1:0]  i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // res_num, res_den, zero pad
    output logic [0:0]  o_m_tuser    // status
);
    import rfa_pkg::*;

    localparam int P = OPERAND_BITS;
    localparam int W = 2 * P + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_GCD   = 5'd2;
    localparam logic [4:0] S_GCDW  = 5'd3;
    localparam logic [4:0] S_LCM   = 5'd4;
    localparam logic [4:0] S_LCMW1 = 5'd5;
    localparam logic [4:0] S_LCM2  = 5'd6;
    localparam logic [4:0] S_LCMW2 = 5'd7;
    localparam logic [4:0] S_M0    = 5'd8;
    localparam logic [4:0] S_M1    = 5'd9;
    localparam logic [4:0] S_M2    = 5'd10;
    localparam logic [4:0] S_SUM   = 5'd11;
    localparam logic [4:0] S_RED   = 5'd12;
    localparam logic [4:0] S_REDW1 = 5'd13;
    localparam logic [4:0] S_RED2  = 5'd14;
    localparam logic [4:0] S_REDW2 = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]   r_state;
    logic [4:0]   r_ret;
    logic [1:0]   r_op;
    logic [P-1:0] r_na, r_da, r_nb, r_db, r_qa, r_qb;
    logic [W-1:0] r_x, r_y, r_mag, r_den, r_ta, r_tb;
    logic         r_neg, r_err;
    logic         r_ovalid;
    logic [71:0]  r_odata;
    logic         r_ostat;

    logic         div_start, div_done;
    logic [W-1:0] div_dvd, div_dvs, div_quo, div_rem;
    logic [P-1:0] mul_a, mul_b;
    logic [2*P-1:0] mul_p;
    logic         op_prod;
    logic [W-1:0] sum_mag;
    logic         sum_zero;
    logic [63:0]  mag64, den64;
    logic [NUM_BITS-1:0] num_out;
    logic         ovf;
    logic         out_free;

    function automatic logic [P-1:0] cut(input logic [IN_FIELD_BITS-1:0] f);
        logic [IN_FIELD_BITS+31:0] wide;
        wide = {32'd0, f};
        return wide[P-1:0];
    endfunction

    rfa_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign op_prod = (r_op == OP_MUL) || (r_op == OP_DIV);

    // magnitude of the combined numerator
    assign sum_mag  = op_prod ? r_ta
                    : (r_op == OP_ADD) ? r_ta + r_tb
                    : (r_ta >= r_tb) ? r_ta - r_tb : r_tb - r_ta;
    assign sum_zero = (sum_mag == '0);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_x;
        div_dvs   = r_y;
        unique case (r_state)
            S_GCD:  div_start = (r_y != '0);
            S_LCM: begin
                div_start = 1'b1;
                div_dvd   = W'(r_da);
                div_dvs   = r_x;
            end
            S_LCM2: begin
                div_start = 1'b1;
                div_dvd   = W'(r_db);
                div_dvs   = r_x;
            end
            S_RED: begin
                div_start = 1'b1;
                div_dvd   = r_mag;
                div_dvs   = r_x;
            end
            S_RED2: begin
                div_start = 1'b1;
                div_dvd   = r_den;
                div_dvs   = r_x;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_M0: begin
                mul_a = op_prod ? r_da : r_qa;
                mul_b = r_db;
            end
            S_M1: begin
                mul_a = op_prod ? r_na : r_qb;
                mul_b = op_prod ? r_nb : r_na;
            end
            default: begin
                mul_a = r_qa;
                mul_b = r_nb;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign mag64    = 64'(r_mag);
    assign den64    = 64'(r_den);
    assign ovf      = (mag64 > 64'h3_FFFF_FFFF) || (den64 > 64'hFFFF_FFFF);
    assign num_out  = r_neg ? (NUM_BITS'(0) - mag64[NUM_BITS-1:0]) : mag64[NUM_BITS-1:0];
    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_s_tvalid) r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_da == '0 || r_db == '0 || (r_op == OP_DIV && r_nb == '0))
                        r_state <= S_OUT;
                    else if (r_op == OP_MUL || r_op == OP_DIV)
                        r_state <= S_M0;
                    else
                        r_state <= S_GCD;
                end
                S_GCD:   r_state <= (r_y == '0) ? r_ret : S_GCDW;
                S_GCDW:  if (div_done) r_state <= S_GCD;
                S_LCM:   r_state <= S_LCMW1;
                S_LCMW1: if (div_done) r_state <= S_LCM2;
                S_LCM2:  r_state <= S_LCMW2;
                S_LCMW2: if (div_done) r_state <= S_M0;
                S_M0:    r_state <= S_M1;
                S_M1:    r_state <= op_prod ? S_SUM : S_M2;
                S_M2:    r_state <= S_SUM;
                // zero sum short-cuts the reduction
                S_SUM:   r_state <= sum_zero ? S_OUT : S_GCD;
                S_RED:   r_state <= S_REDW1;
                S_REDW1: if (div_done) r_state <= S_RED2;
                S_RED2:  r_state <= S_REDW2;
                S_REDW2: if (div_done) r_state <= S_FIN;
                S_FIN:   r_state <= S_OUT;
                S_OUT:   if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op  <= i_s_tuser;
                r_na  <= cut(i_s_tdata[15:0]);
                r_da  <= cut(i_s_tdata[31:16]);
                r_nb  <= cut(i_s_tdata[47:32]);
                r_db  <= cut(i_s_tdata[63:48]);
                r_err <= 1'b0;
                r_neg <= 1'b0;
            end
            S_CHECK: begin
                if (r_da == '0 || r_db == '0 || (r_op == OP_DIV && r_nb == '0))
                    r_err <= 1'b1;
                if (r_op == OP_DIV) begin
                    r_nb <= r_db;
                    r_db <= r_nb;
                end
                r_x   <= W'(r_da);
                r_y   <= W'(r_db);
                r_ret <= S_LCM;
            end
            S_GCDW: if (div_done) begin
                r_x <= r_y;
                r_y <= div_rem;
            end
            S_LCMW1: if (div_done) r_qa <= div_quo[P-1:0];
            S_LCMW2: if (div_done) r_qb <= div_quo[P-1:0];
            S_M0:    r_den <= W'(mul_p);
            S_M1:    r_ta  <= W'(mul_p);
            S_M2:    r_tb  <= W'(mul_p);
            S_SUM: begin
                // zero result is 0/1
                if (sum_zero) begin
                    r_mag <= '0;
                    r_den <= W'(1);
                end else begin
                    r_mag <= sum_mag;
                end
                r_neg <= (r_op == OP_SUB) && (r_ta < r_tb);
                r_x   <= sum_mag;
                r_y   <= r_den;
                r_ret <= S_RED;
            end
            S_REDW1: if (div_done) r_mag <= div_quo;
            S_REDW2: if (div_done) r_den <= div_quo;
            S_FIN:   if (ovf) r_err <= 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_ostat <= r_err;
            r_odata <= r_err ? 72'd0 : {5'd0, den64[DEN_BITS-1:0], num_out};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;

`ifndef ASSERT_OFF
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[66:35] != '0)
        else $error("good result with zero denominator");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("error result not cleared");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_GCDW || r_state == S_LCMW1 || r_state == S_LCMW2 ||
                      r_state == S_REDW1 || r_state == S_REDW2))
        else $error("divider finished outside a wait step");
`endif
endmodule

/* src/rfa_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module rfa_div #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic [W:0]    sh;
    logic [W:0]    diff;
    logic          ge;

    assign sh   = {r_rem, r_quo[W-1]};
    assign diff = sh - {1'b0, r_dvs};
    assign ge   = !diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1))
                    r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : sh[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_divisor != '0) else $error("divide by zero started");
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_dvs) else $error("remainder not below divisor");
`endif
endmodule

/* tb/sv/rational_fraction_alu_unit_tb.sv */
// Self-checking testbench for the rational fraction ALU: directed table, then random items.
module rational_fraction_alu_unit_tb;
    import rfa_pkg::*;

    localparam int N_RANDOM = 530;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] na, da, nb, db;
        bit          typed;      // expected result given in the row
        t_res_num    e_num;
        t_res_den    e_den;
        logic        e_err;
    } t_row;

    typedef struct {
        t_res_num num;
        t_res_den den;
        logic     err;
    } t_fraction_res;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;

    t_fraction_res pending_results[$];
    int            fail_count;
    longint        cycle_count;
    bit            stim_done;
    bit            calm_phase;   // no idling near the end of the run
    bit            hold_off_req;

    rational_fraction_alu_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_res reduce_fraction(logic [1:0] op, logic [15:0] na_i,
                                                      logic [15:0] da_i, logic [15:0] nb_i,
                                                      logic [15:0] db_i);
        t_fraction_res r;
        longint unsigned na, da, nb, db, mag, den, g, l, ta, tb, t;
        bit neg;
        na = 64'(na_i); da = 64'(da_i); nb = 64'(nb_i); db = 64'(db_i);
        neg = 1'b0;
        r.num = '0; r.den = '0; r.err = 1'b1;
        if (da == 0 || db == 0) return r;
        if (op == OP_DIV) begin
            if (nb == 0) return r;
            t = nb; nb = db; db = t;
        end
        if (op == OP_MUL || op == OP_DIV) begin
            mag = na * nb;
            den = da * db;
        end else begin
            l = (da / euclid_gcd(da, db)) * db;
            ta = (l / da) * na;
            tb = (l / db) * nb;
            den = l;
            if (op == OP_ADD) mag = ta + tb;
            else if (ta >= tb) mag = ta - tb;
            else begin
                mag = tb - ta;
                neg = 1'b1;
            end
        end
        r.err = 1'b0;
        if (mag == 0) begin
            r.den = t_res_den'(1);
            return r;
        end
        g = euclid_gcd(mag, den);
        mag = mag / g;
        den = den / g;
        r.num = neg ? t_res_num'(-mag) : t_res_num'(mag);
        r.den = t_res_den'(den);
        return r;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hffff - 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(1, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                             logic [15:0] nb, logic [15:0] db);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {db, nb, da, na};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Queue the expectation as the transfer is accepted
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(reduce_fraction(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                                      s_tdata[47:32], s_tdata[63:48]));
    end

    always @(posedge clk) begin
        t_fraction_res exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result num=%0h den=%0h", m_tdata[34:0], m_tdata[66:35]);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[34:0] !== exp_r.num) begin
                    $error("res_num expected %0h actual %0h", exp_r.num, m_tdata[34:0]);
                    fail_count++;
                end
                if (m_tdata[66:35] !== exp_r.den) begin
                    $error("res_den expected %0h actual %0h", exp_r.den, m_tdata[66:35]);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_r.err) begin
                    $error("status expected %0b actual %0b", exp_r.err, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls: random bursts, plus one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (6000) @(negedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rational_fraction_alu_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_row dir_rows[$];
        t_fraction_res chk;
        logic [1:0] op;
        int tail;
        fail_count = 0;
        cycle_count = 0;
        calm_phase = 1'b0;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;

        // zero denominators and divide by zero: typed error; zero results: typed 0/1; others from the predictor
        dir_rows.push_back('{OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1, '0, '0, 1'b1});
        dir_rows.push_back('{OP_SUB, 16'd1, 16'd1, 16'd1, 16'd0, 1, '0, '0, 1'b1});
        dir_rows.push_back('{OP_MUL, 16'd0, 16'd0, 16'd0, 16'd0, 1, '0, '0, 1'b1});
        dir_rows.push_back('{OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7, 1, '0, '0, 1'b1});
        dir_rows.push_back('{OP_ADD, 16'd0, 16'd5, 16'd0, 16'd9, 1, '0, 32'd1, 1'b0});
        dir_rows.push_back('{OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4, 1, '0, 32'd1, 1'b0});
        dir_rows.push_back('{OP_MUL, 16'd0, 16'd7, 16'd9, 16'd2, 1, '0, 32'd1, 1'b0});
        dir_rows.push_back('{OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_SUB, 16'd1, 16'd3, 16'd1, 16'd2, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_MUL, 16'd2, 16'd3, 16'd9, 16'd4, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_DIV, 16'd2, 16'd3, 16'd4, 16'd9, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hfffe, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_SUB, 16'd0, 16'hffff, 16'hffff, 16'd1, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_MUL, 16'hffff, 16'd1, 16'hffff, 16'd1, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_DIV, 16'hffff, 16'd1, 16'd1, 16'hffff, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_DIV, 16'd1, 16'hffff, 16'hffff, 16'd1, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_ADD, 16'hfffe, 16'hffff, 16'hfffd, 16'hfffb, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_SUB, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0, '0, '0, 1'b0});
        dir_rows.push_back('{OP_MUL, 16'h8000, 16'h0001, 16'h0001, 16'h8000, 0, '0, '0, 1'b0});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                chk = reduce_fraction(dir_rows[i].op, dir_rows[i].na, dir_rows[i].da,
                                      dir_rows[i].nb, dir_rows[i].db);
                if (chk.num !== dir_rows[i].e_num || chk.den !== dir_rows[i].e_den ||
                    chk.err !== dir_rows[i].e_err) begin
                    $error("table row %0d disagrees with predictor", i);
                    fail_count++;
                end
            end
            send_item(dir_rows[i].op, dir_rows[i].na, dir_rows[i].da,
                      dir_rows[i].nb, dir_rows[i].db);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 60) hold_off_req = 1'b1;
            if (k == N_RANDOM - 60) calm_phase = 1'b1;
            op = 2'($urandom_range(0, 3));
            send_item(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge clk);
        tail = 0;
        while (tail < 3000) begin
            @(posedge clk);
            tail++;
        end
        if (fail_count == 0 && pending_results.size() == 0)
            $display("rational_fraction_alu_unit verification clean");
        else
            $display("rational_fraction_alu_unit verification failed");
        $finish;
    end
endmodule
